// ----- hw/rtl/mkf_pkg.sv -----
// Package for the morph keyframe interpolator: widths, codes, state encoding
// and the control struct handed to the key cells. No dependencies.
package mkf_pkg;

    localparam int KEYS_DEF = 64;
    localparam int TIME_W   = 24;
    localparam int WGT_W    = 16;
    localparam int SEEK_W   = 32;
    localparam int CFG_W    = 32;
    localparam int CFG_IW   = 3;
    localparam int RATE_W   = 17;
    localparam int TW       = 37;  // signed width for 24.8 time arithmetic
    localparam int MAG_W    = 36;  // magnitude of a time difference
    localparam int NUM_W    = 53;  // dividend width, product plus rounding term
    localparam int DEN_W    = 36;  // divisor width
    localparam int WINDOW   = 60 * 256;
    localparam int RATE_ONE = 65536;

    typedef enum logic [1:0] {
        FN_LOAD     = 2'd0,
        FN_SEEK     = 2'd1,
        FN_SNAPSHOT = 2'd2,
        FN_REWIND   = 2'd3
    } mkf_func_t;

    typedef enum logic [2:0] {
        REG_OVERRIDE = 3'd0,
        REG_LOOP     = 3'd1,
        REG_SMEAR    = 3'd2,
        REG_RATE     = 3'd3,
        REG_SKIP     = 3'd4
    } mkf_reg_t;

    typedef enum logic [3:0] {
        S_IDLE, S_RO, S_SCAN, S_SETUP, S_DIFF, S_MUL_LO, S_MUL_HI,
        S_DIV_GO, S_DIV, S_TRACK, S_BLEND1, S_BLEND2, S_BLEND3, S_DONE
    } mkf_state_t;

    typedef struct packed {
        logic ins;      // insert new key into the sorted row
        logic load_ro;  // copy keys into the read-out chain
        logic shift;    // move read-out chain one cell toward cell zero
    } mkf_cell_ctrl_t;

    function automatic logic signed [WGT_W-1:0] sat16(input logic signed [19:0] v);
        if (v > 20'sd32767) return 16'sh7fff;
        if (v < -20'sd32768) return 16'sh8000;
        return v[WGT_W-1:0];
    endfunction

endpackage

// ----- hw/rtl/mkf_cell.sv -----
// One key cell: holds a keyframe time and weight and a read-out stage.
// Depends on mkf_pkg.
module mkf_cell #(
    parameter int KEYS = mkf_pkg::KEYS_DEF,
    parameter int IDX  = 0
) (
    input  logic                                   clk,
    input  mkf_pkg::mkf_cell_ctrl_t                ctrl,
    input  logic [$clog2(KEYS+1)-1:0]              count,
    input  logic [mkf_pkg::TIME_W-1:0]             new_time,
    input  logic signed [mkf_pkg::WGT_W-1:0]       new_weight,
    input  logic [mkf_pkg::TIME_W-1:0]             left_time,
    input  logic signed [mkf_pkg::WGT_W-1:0]       left_weight,
    input  logic [mkf_pkg::TIME_W-1:0]             right_ro_time,
    input  logic signed [mkf_pkg::WGT_W-1:0]       right_ro_weight,
    output logic [mkf_pkg::TIME_W-1:0]             key_time,
    output logic signed [mkf_pkg::WGT_W-1:0]       key_weight,
    output logic [mkf_pkg::TIME_W-1:0]             ro_time,
    output logic signed [mkf_pkg::WGT_W-1:0]       ro_weight
);
    import mkf_pkg::*;

    localparam int CW = $clog2(KEYS+1);
    localparam logic [CW-1:0] IDX_C = CW'(IDX);

    logic [TIME_W-1:0]       time_reg;
    logic signed [WGT_W-1:0] weight_reg;
    logic [TIME_W-1:0]       ro_time_reg;
    logic signed [WGT_W-1:0] ro_weight_reg;
    logic                    take_left;
    logic                    put_new;

    // The left neighbor moves in when its key is later than the new one;
    // the new key lands where the left key is not later and this one is.
    always_comb
    begin
        take_left = (IDX != 0) && (IDX_C <= count) && (left_time > new_time);
        put_new   = !take_left && (IDX_C <= count) &&
                    ((IDX_C == count) || (time_reg > new_time));
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.ins && take_left)
        begin
            time_reg   <= left_time;
            weight_reg <= left_weight;
        end
        else if (ctrl.ins && put_new)
        begin
            time_reg   <= new_time;
            weight_reg <= new_weight;
        end
        if (ctrl.load_ro)
        begin
            ro_time_reg   <= time_reg;
            ro_weight_reg <= weight_reg;
        end
        else if (ctrl.shift)
        begin
            ro_time_reg   <= right_ro_time;
            ro_weight_reg <= right_ro_weight;
        end
    end

    assign key_time   = time_reg;
    assign key_weight = weight_reg;
    assign ro_time    = ro_time_reg;
    assign ro_weight  = ro_weight_reg;

endmodule

// ----- hw/rtl/mkf_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on mkf_pkg.
module mkf_div #(
    parameter int NW = mkf_pkg::NUM_W,
    parameter int DW = mkf_pkg::DEN_W
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          go,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [NW-1:0] quo
);
    import mkf_pkg::*;

    localparam int CNW = $clog2(NW+1);

    logic [DW-1:0]  rem_reg;
    logic [DW-1:0]  den_reg;
    logic [NW-1:0]  quo_reg;
    logic [CNW-1:0] cnt_reg;
    logic           run_reg;
    logic           done_reg;
    logic [DW:0]    trial;
    logic           fits;

    always_comb
    begin
        trial = {rem_reg, quo_reg[NW-1]};
        fits  = trial >= {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= !go && run_reg && (cnt_reg == CNW'(NW-1));
            if (go)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNW'(NW-1))
                    run_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            rem_reg <= '0;
            den_reg <= den;
            quo_reg <= num;
        end
        else if (run_reg)
        begin
            rem_reg <= fits ? DW'(trial - {1'b0, den_reg}) : trial[DW-1:0];
            quo_reg <= {quo_reg[NW-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// ----- hw/rtl/morph_keyframe_interpolator_unit.sv -----
// Top level of the morph keyframe interpolator: controller, a row of key
// cells and a single divider. Depends on mkf_pkg, mkf_cell and mkf_div.
//
//  Channel   Signals                                  Handshake
//  --------  ---------------------------------------  ---------------------------
//  request   func, key_frame, key_weight, seek_time   taken when start && !busy
//  result    face_weight, updated, table_full,        valid while done is high,
//            key_count                                one cycle, no back-pressure
//  config    cfg_we, cfg_index, cfg_data              written when cfg_we is high
//
// Load, snapshot and rewind requests and skipped seeks go straight to the done
// state: done is high in the cycle right after the accepting edge. A full seek
// streams the keys out of the cell row, picks the bracketing pair, multiplies
// and starts the divider, runs the bit-serial divider, then rounds, saturates,
// blends and shows the result. Equal bracketing times skip the divider, and a
// blend rate of one skips the second blend multiply and the rounding state.
// Reset is asynchronous and active low; the key table itself is not cleared,
// only the key count, so entries are never read before they are written.
// The receiver cannot stall; each result is shown for exactly one cycle.
module morph_keyframe_interpolator_unit #(
    parameter int KEYS = mkf_pkg::KEYS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    output logic                                done,
    input  logic [1:0]                          func,
    input  logic [mkf_pkg::TIME_W-1:0]          key_frame,
    input  logic signed [mkf_pkg::WGT_W-1:0]    key_weight,
    input  logic [mkf_pkg::SEEK_W-1:0]          seek_time,
    output logic signed [mkf_pkg::WGT_W-1:0]    face_weight,
    output logic                                updated,
    output logic                                table_full,
    output logic [$clog2(KEYS+1)-1:0]           key_count,
    input  logic                                cfg_we,
    input  logic [mkf_pkg::CFG_IW-1:0]          cfg_index,
    input  logic [mkf_pkg::CFG_W-1:0]           cfg_data
);
    import mkf_pkg::*;

    localparam int CW = $clog2(KEYS+1);
    localparam int IW = $clog2(KEYS);

    // Configuration registers.
    logic              override_reg;
    logic [31:0]       loop_reg;
    logic [31:0]       smear_reg;
    logic [RATE_W-1:0] rate_reg;
    logic              skip_reg;

    // Track state.
    mkf_state_t              state_reg, state_next;
    logic [CW-1:0]           count_reg;
    logic [IW-1:0]           sstart_reg;
    logic [TIME_W-1:0]       last_reg;
    logic signed [WGT_W-1:0] track_reg;
    logic signed [WGT_W-1:0] snap_reg;
    logic signed [WGT_W-1:0] blend_reg;
    logic                    upd_reg;
    logic                    full_reg;

    // Seek working registers.
    logic [SEEK_W-1:0]       req_reg;
    logic [SEEK_W-1:0]       cur_reg;
    logic [IW-1:0]           start_idx_reg;
    logic [IW-1:0]           scan_reg;
    logic                    found_reg;
    logic [IW-1:0]           k1_reg;
    logic                    k1_zero_reg;
    logic [TIME_W-1:0]       t1_reg, t2_reg, prev_t_reg;
    logic signed [WGT_W-1:0] w1_reg, w2_reg, prev_w_reg;
    logic signed [TW-1:0]    tf_reg, tt_reg, cs_reg;
    logic signed [WGT_W-1:0] wf_reg, wt_reg;
    logic [WGT_W-1:0]        ma_reg;
    logic [MAG_W-1:0]        mb_reg;
    logic [DEN_W-1:0]        dmag_reg;
    logic                    neg_reg;
    logic                    den_zero_reg;
    logic [NUM_W-1:0]        acc_reg;
    logic [RATE_W-1:0]       r_reg;
    logic signed [33:0]      prod_reg;
    logic signed [34:0]      sum_reg;

    mkf_cell_ctrl_t          cell_ctrl;
    logic                    accept;
    logic                    can_insert;
    logic                    seek_skip;
    logic                    div_go;
    logic                    div_done;
    logic [NUM_W-1:0]        div_quo;

    logic [TIME_W-1:0]       cell_time   [KEYS];
    logic signed [WGT_W-1:0] cell_weight [KEYS];
    logic [TIME_W-1:0]       ro_time     [KEYS];
    logic signed [WGT_W-1:0] ro_weight   [KEYS];

    assign accept     = start && (state_reg == S_IDLE);
    assign can_insert = count_reg < CW'(KEYS);
    assign seek_skip  = (count_reg == '0) || (skip_reg && (count_reg <= CW'(1)));

    // The row of key cells. Each cell looks left for insertion shifts and
    // right for the read-out stream, which drains toward cell zero.
    for (genvar g = 0; g < KEYS; g++)
    begin : g_cell
        logic [TIME_W-1:0]       lt;
        logic signed [WGT_W-1:0] lw;
        logic [TIME_W-1:0]       rt;
        logic signed [WGT_W-1:0] rw;
        if (g == 0)
        begin : g_first
            assign lt = '0;
            assign lw = '0;
        end
        else
        begin : g_mid
            assign lt = cell_time[g-1];
            assign lw = cell_weight[g-1];
        end
        if (g == KEYS - 1)
        begin : g_last
            assign rt = '0;
            assign rw = '0;
        end
        else
        begin : g_inner
            assign rt = ro_time[g+1];
            assign rw = ro_weight[g+1];
        end
        mkf_cell #(.KEYS(KEYS), .IDX(g)) u_cell (
            .clk             (clk),
            .ctrl            (cell_ctrl),
            .count           (count_reg),
            .new_time        (key_frame),
            .new_weight      (key_weight),
            .left_time       (lt),
            .left_weight     (lw),
            .right_ro_time   (rt),
            .right_ro_weight (rw),
            .key_time        (cell_time[g]),
            .key_weight      (cell_weight[g]),
            .ro_time         (ro_time[g]),
            .ro_weight       (ro_weight[g])
        );
    end

    mkf_div #(.NW(NUM_W), .DW(DEN_W)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (div_go),
        .num   (acc_reg + NUM_W'(dmag_reg >> 1)),
        .den   (dmag_reg),
        .done  (div_done),
        .quo   (div_quo)
    );

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if ((func == FN_SEEK) && !seek_skip)
                        state_next = S_RO;
                    else
                        state_next = S_DONE;
                end
            end
            S_RO:     state_next = S_SCAN;
            S_SCAN:
            begin
                if (CW'(scan_reg) == count_reg - 1'b1)
                    state_next = S_SETUP;
            end
            S_SETUP:  state_next = S_DIFF;
            S_DIFF:   state_next = S_MUL_LO;
            S_MUL_LO: state_next = den_zero_reg ? S_BLEND1 : S_MUL_HI;
            S_MUL_HI: state_next = S_DIV_GO;
            S_DIV_GO: state_next = S_DIV;
            S_DIV:    state_next = div_done ? S_TRACK : S_DIV;
            S_TRACK:  state_next = S_BLEND1;
            S_BLEND1: state_next = (r_reg == RATE_W'(RATE_ONE)) ? S_DONE : S_BLEND2;
            S_BLEND2: state_next = S_BLEND3;
            S_BLEND3: state_next = S_DONE;
            S_DONE:   state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // Output and control decode.
    always_comb
    begin
        cell_ctrl.ins     = accept && (func == FN_LOAD) && can_insert;
        cell_ctrl.load_ro = state_reg == S_RO;
        cell_ctrl.shift   = state_reg == S_SCAN;
        div_go            = state_reg == S_DIV_GO;
        busy              = state_reg != S_IDLE;
        done              = state_reg == S_DONE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            override_reg <= 1'b0;
            loop_reg     <= '0;
            smear_reg    <= '0;
            rate_reg     <= RATE_W'(RATE_ONE);
            skip_reg     <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_OVERRIDE: override_reg <= cfg_data[0];
                REG_LOOP:     loop_reg     <= cfg_data;
                REG_SMEAR:    smear_reg    <= cfg_data;
                REG_RATE:     rate_reg     <= cfg_data[RATE_W-1:0];
                REG_SKIP:     skip_reg     <= cfg_data[0];
                default:      ;
            endcase
        end
    end

    // Scan step: the head of the read-out chain is entry scan_reg. The first
    // key at or after the clamped time brackets it, except that when the time
    // is not before the remembered key, a match at that key wins over an equal
    // earlier one.
    logic [SEEK_W-1:0] head_t;
    logic              at_or_after;
    logic              not_before;
    logic              capture;

    always_comb
    begin
        head_t      = {ro_time[0], 8'd0};
        at_or_after = cur_reg <= head_t;
        not_before  = cur_reg >= head_t;
        capture     = at_or_after &&
                      (!found_reg || ((scan_reg == start_idx_reg) && not_before));
    end

    // Override selection of the interpolation end points.
    logic signed [TW-1:0]    lst, sml, tf0, tt0, req_s, cur_s;
    logic signed [TW-1:0]    tf_sel, tt_sel, cs_sel;
    logic signed [WGT_W-1:0] wf_sel, wt_sel;
    logic                    ovr, multi;

    always_comb
    begin
        lst   = TW'($signed({1'b0, loop_reg}));
        sml   = TW'($signed({1'b0, smear_reg}));
        tf0   = TW'($signed({1'b0, t1_reg, 8'd0}));
        tt0   = TW'($signed({1'b0, t2_reg, 8'd0}));
        req_s = TW'($signed({1'b0, req_reg}));
        cur_s = TW'($signed({1'b0, cur_reg}));
        ovr   = override_reg && (k1_zero_reg || (tf0 <= lst));
        multi = count_reg > CW'(1);

        tf_sel = tf0;
        tt_sel = tt0;
        cs_sel = cur_s;
        wf_sel = w1_reg;
        wt_sel = w2_reg;
        if (ovr)
        begin
            if (multi && (tt0 < lst + TW'(WINDOW)))
            begin
                tf_sel = lst;
                wf_sel = snap_reg;
            end
            else if (req_s - tf0 < sml)
            begin
                tf_sel = lst;
                tt_sel = lst + sml;
                cs_sel = req_s;
                wf_sel = snap_reg;
                wt_sel = w1_reg;
            end
            else if (multi)
                tf_sel = lst + sml;
            else
                wt_sel = '0;
        end
    end

    // Difference magnitudes for the multiply and divide.
    logic signed [WGT_W:0] dw;
    logic signed [TW-1:0]  dt, dd;

    always_comb
    begin
        dw = (WGT_W+1)'(wt_reg) - (WGT_W+1)'(wf_reg);
        dt = cs_reg - tf_reg;
        dd = tt_reg - tf_reg;
    end

    // Rounding and saturation of the quotient and of the blend.
    logic [WGT_W-1:0]      qsat;
    logic signed [19:0]    track_sum;
    logic [34:0]           smag;
    logic [18:0]           bq;
    logic signed [19:0]    bval;

    always_comb
    begin
        qsat      = (|div_quo[NUM_W-1:WGT_W]) ? {WGT_W{1'b1}} : div_quo[WGT_W-1:0];
        track_sum = 20'(wf_reg) + (neg_reg ? -20'($signed({4'd0, qsat}))
                                           : 20'($signed({4'd0, qsat})));
        smag      = sum_reg[34] ? 35'(-sum_reg) : 35'(sum_reg);
        bq        = 19'((36'(smag) + 36'd32768) >> 16);
        bval      = sum_reg[34] ? -20'($signed({1'b0, bq})) : 20'($signed({1'b0, bq}));
    end

    // Track state and request flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            sstart_reg <= '0;
            last_reg   <= '0;
            track_reg  <= '0;
            snap_reg   <= '0;
            blend_reg  <= '0;
            upd_reg    <= 1'b0;
            full_reg   <= 1'b0;
            found_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                upd_reg  <= (func == FN_SEEK) && !seek_skip;
                full_reg <= (func == FN_LOAD) && !can_insert;
                unique case (mkf_func_t'(func))
                    FN_LOAD:
                    begin
                        if (can_insert)
                        begin
                            count_reg <= count_reg + 1'b1;
                            if ((count_reg == '0) || (key_frame >= last_reg))
                                last_reg <= key_frame;
                        end
                    end
                    FN_SNAPSHOT: snap_reg   <= blend_reg;
                    FN_REWIND:   sstart_reg <= '0;
                    default:     ;
                endcase
            end
            if (state_reg == S_RO)
                found_reg <= 1'b0;
            if ((state_reg == S_SCAN) && capture)
                found_reg <= 1'b1;
            if (state_reg == S_SETUP)
                sstart_reg <= k1_reg;
            if ((state_reg == S_MUL_LO) && den_zero_reg)
                track_reg <= wf_reg;
            if (state_reg == S_TRACK)
                track_reg <= sat16(track_sum);
            if ((state_reg == S_BLEND1) && (r_reg == RATE_W'(RATE_ONE)))
                blend_reg <= track_reg;
            if (state_reg == S_BLEND3)
                blend_reg <= sat16(bval);
        end
    end

    // Seek datapath registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg       <= seek_time;
            cur_reg       <= (seek_time > {last_reg, 8'd0}) ? {last_reg, 8'd0} : seek_time;
            start_idx_reg <= (CW'(sstart_reg) < count_reg) ? sstart_reg : '0;
            scan_reg      <= '0;
            r_reg         <= (rate_reg > RATE_W'(RATE_ONE)) ? RATE_W'(RATE_ONE) : rate_reg;
        end
        if (state_reg == S_SCAN)
        begin
            scan_reg   <= scan_reg + 1'b1;
            prev_t_reg <= ro_time[0];
            prev_w_reg <= ro_weight[0];
            if (capture)
            begin
                t2_reg <= ro_time[0];
                w2_reg <= ro_weight[0];
                if (scan_reg == '0)
                begin
                    t1_reg      <= ro_time[0];
                    w1_reg      <= ro_weight[0];
                    k1_reg      <= '0;
                    k1_zero_reg <= 1'b1;
                end
                else
                begin
                    t1_reg      <= prev_t_reg;
                    w1_reg      <= prev_w_reg;
                    k1_reg      <= scan_reg - 1'b1;
                    k1_zero_reg <= scan_reg == IW'(1);
                end
            end
        end
        if (state_reg == S_SETUP)
        begin
            tf_reg <= tf_sel;
            tt_reg <= tt_sel;
            cs_reg <= cs_sel;
            wf_reg <= wf_sel;
            wt_reg <= wt_sel;
        end
        if (state_reg == S_DIFF)
        begin
            ma_reg       <= dw[WGT_W] ? WGT_W'(-dw) : WGT_W'(dw);
            mb_reg       <= dt[TW-1] ? MAG_W'(-dt) : MAG_W'(dt);
            dmag_reg     <= dd[TW-1] ? DEN_W'(-dd) : DEN_W'(dd);
            neg_reg      <= dw[WGT_W] ^ dt[TW-1] ^ dd[TW-1];
            den_zero_reg <= dd == '0;
        end
        if (state_reg == S_MUL_LO)
            acc_reg <= NUM_W'(ma_reg * mb_reg[17:0]);
        if (state_reg == S_MUL_HI)
            acc_reg <= acc_reg + (NUM_W'(ma_reg * mb_reg[MAG_W-1:18]) << 18);
        if (state_reg == S_BLEND1)
            prod_reg <= 34'(blend_reg) * 34'($signed({1'b0, RATE_W'(RATE_ONE) - r_reg}));
        if (state_reg == S_BLEND2)
            sum_reg <= 35'(prod_reg) + 35'(track_reg) * 35'($signed({1'b0, r_reg}));
    end

    assign face_weight = blend_reg;
    assign updated     = upd_reg;
    assign table_full  = full_reg;
    assign key_count   = count_reg;

endmodule

// ----- hw/rtl/mkf_checker.sv -----
// Port-level checker for the morph keyframe interpolator and its bind.
// Depends on mkf_pkg and morph_keyframe_interpolator_unit.
module mkf_checker #(
    parameter int KEYS = mkf_pkg::KEYS_DEF
) (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      start,
    input logic                      busy,
    input logic                      done,
    input logic                      updated,
    input logic                      table_full,
    input logic [$clog2(KEYS+1)-1:0] key_count
);
    import mkf_pkg::*;

    // A result closes the request, so the unit is still busy while showing it.
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n) done |-> busy)
        else $error("done without busy");

    // Each result is shown for one cycle only.
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("done held longer than one cycle");

    // An accepted request makes the unit busy.
    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted but unit not busy");

    // A dropped load means the table is full and nothing was recomputed.
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        (done && table_full) |-> ((key_count == ($clog2(KEYS+1))'(KEYS)) && !updated))
        else $error("table_full with room left or with updated set");

endmodule

bind morph_keyframe_interpolator_unit mkf_checker #(.KEYS(KEYS)) u_mkf_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .updated    (updated),
    .table_full (table_full),
    .key_count  (key_count)
);

// ----- sim/morph_keyframe_interpolator_unit_tb.sv -----
// Self-checking testbench for the morph keyframe interpolator: keyframe loads,
// seeks with smearing and blending, snapshots and rewinds, checked per result.
// Depends on mkf_pkg and the morph_keyframe_interpolator_unit RTL.
`timescale 1ns / 100ps

// Holds the track state the block should have and the queue of expected
// results; every accepted request updates the track and queues one result.
class mkf_track_scoreboard;
    typedef struct packed {
        logic signed [15:0] face_weight;
        logic               updated;
        logic               table_full;
        logic [6:0]         key_count;
    } face_result_t;

    logic [23:0]        key_times[64];
    logic signed [15:0] key_weights[64];
    int unsigned        keys_held;
    int unsigned        search_start;
    longint             track_weight;
    longint             snapshot_weight;
    longint             blended_weight;
    bit                 override_first;
    longint             loop_start_time;
    longint             smear_length;
    int unsigned        blend_rate;
    bit                 skip_single_key;
    face_result_t       pending_results[$];
    int                 error_count;

    function new();
        keys_held = 0;
        search_start = 0;
        track_weight = 0;
        snapshot_weight = 0;
        blended_weight = 0;
        override_first = 0;
        loop_start_time = 0;
        smear_length = 0;
        blend_rate = 65536;
        skip_single_key = 0;
        error_count = 0;
    endfunction

    function void write_reg(mkf_pkg::mkf_reg_t idx, logic [31:0] data);
        case (idx)
            mkf_pkg::REG_OVERRIDE: override_first = data[0];
            mkf_pkg::REG_LOOP:     loop_start_time = data;
            mkf_pkg::REG_SMEAR:    smear_length = data;
            mkf_pkg::REG_RATE:     blend_rate = data[16:0];
            mkf_pkg::REG_SKIP:     skip_single_key = data[0];
            default: ;
        endcase
    endfunction

    static function longint round_div(longint num, longint den);
        bit     neg;
        longint n;
        longint d;
        longint q;
        neg = (num < 0) != (den < 0);
        n = num < 0 ? -num : num;
        d = den < 0 ? -den : den;
        q = (n + d / 2) / d;
        return neg ? -q : q;
    endfunction

    static function longint clamp16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function void seek_track(logic [31:0] seek);
        longint      last;
        longint      req;
        longint      cur;
        longint      tf;
        longint      tt;
        longint      wf;
        longint      wt;
        int unsigned first;
        int unsigned k1;
        int unsigned k2;
        last = longint'(key_times[keys_held - 1]) * 256;
        req = seek;
        cur = req > last ? last : req;
        first = search_start < keys_held ? search_start : 0;
        k2 = 0;
        if (cur >= longint'(key_times[first]) * 256) begin
            for (int i = first; i < keys_held; i++)
                if (cur <= longint'(key_times[i]) * 256) begin
                    k2 = i;
                    break;
                end
        end
        else begin
            for (int i = 0; i <= first && i < keys_held; i++)
                if (cur <= longint'(key_times[i]) * 256) begin
                    k2 = i;
                    break;
                end
        end
        if (k2 >= keys_held) k2 = keys_held - 1;
        k1 = k2 <= 1 ? 0 : k2 - 1;
        search_start = k1;
        tf = longint'(key_times[k1]) * 256;
        tt = longint'(key_times[k2]) * 256;
        if (override_first && (k1 == 0 || tf <= loop_start_time)) begin
            if (keys_held > 1 && tt < loop_start_time + 60 * 256) begin
                tf = loop_start_time;
                wf = snapshot_weight;
                wt = key_weights[k2];
            end
            else if (req - tf < smear_length) begin
                tf = loop_start_time;
                tt = loop_start_time + smear_length;
                cur = req;
                wf = snapshot_weight;
                wt = key_weights[k1];
            end
            else if (keys_held > 1) begin
                tf = loop_start_time + smear_length;
                wf = key_weights[k1];
                wt = key_weights[k2];
            end
            else begin
                wf = key_weights[k1];
                wt = 0;
            end
        end
        else begin
            wf = key_weights[k1];
            wt = key_weights[k2];
        end
        if (tf != tt)
            track_weight = clamp16(wf + round_div((wt - wf) * (cur - tf), tt - tf));
        else
            track_weight = wf;
    endfunction

    // Notes one accepted request and queues the result it must produce.
    function void note_request(mkf_pkg::mkf_func_t fn, logic [23:0] frame,
                               logic signed [15:0] weight, logic [31:0] seek);
        face_result_t res;
        int unsigned  pos;
        int unsigned  rate;
        res = '0;
        case (fn)
            mkf_pkg::FN_LOAD:
                if (keys_held >= 64) res.table_full = 1'b1;
                else begin
                    pos = keys_held;
                    while (pos > 0 && key_times[pos - 1] > frame) begin
                        key_times[pos] = key_times[pos - 1];
                        key_weights[pos] = key_weights[pos - 1];
                        pos--;
                    end
                    key_times[pos] = frame;
                    key_weights[pos] = weight;
                    keys_held++;
                end
            mkf_pkg::FN_SEEK:
                if (!(keys_held == 0 || (skip_single_key && keys_held <= 1))) begin
                    seek_track(seek);
                    rate = blend_rate > 65536 ? 65536 : blend_rate;
                    if (rate == 65536) blended_weight = track_weight;
                    else
                        blended_weight = clamp16(round_div(blended_weight *
                            (65536 - rate) + track_weight * rate, 65536));
                    res.updated = 1'b1;
                end
            mkf_pkg::FN_SNAPSHOT: snapshot_weight = blended_weight;
            default: search_start = 0;
        endcase
        res.face_weight = blended_weight[15:0];
        res.key_count = keys_held[6:0];
        pending_results = {pending_results, res};
    endfunction

    // Compares one result from the block with the oldest expectation.
    function void check_result(face_result_t got);
        face_result_t want;
        if (pending_results.size() == 0) begin
            $error("unexpected result: face_weight %0d", got.face_weight);
            error_count++;
            return;
        end
        want = pending_results.pop_front();
        if (got.face_weight !== want.face_weight) begin
            $error("face_weight: expected %0d, got %0d", want.face_weight,
                   got.face_weight);
            error_count++;
        end
        if (got.updated !== want.updated) begin
            $error("updated: expected %0d, got %0d", want.updated, got.updated);
            error_count++;
        end
        if (got.table_full !== want.table_full) begin
            $error("table_full: expected %0d, got %0d", want.table_full,
                   got.table_full);
            error_count++;
        end
        if (got.key_count !== want.key_count) begin
            $error("key_count: expected %0d, got %0d", want.key_count,
                   got.key_count);
            error_count++;
        end
    endfunction
endclass

module morph_keyframe_interpolator_unit_tb;
    import mkf_pkg::*;

    // No request may sit this many cycles without anything being accepted.
    // The slowest seek ends far below this limit.
    localparam int WATCHDOG_LIMIT = 20000;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic               done;
    logic [1:0]         func;
    logic [23:0]        key_frame;
    logic signed [15:0] key_weight;
    logic [31:0]        seek_time;
    logic signed [15:0] face_weight;
    logic               updated;
    logic               table_full;
    logic [6:0]         key_count;
    logic               cfg_we;
    logic [2:0]         cfg_index;
    logic [31:0]        cfg_data;

    mkf_track_scoreboard track_sb;
    int                  idle_pct;
    int                  quiet_cycles;
    logic [23:0]         frame_base;

    morph_keyframe_interpolator_unit u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .done       (done),
        .func       (func),
        .key_frame  (key_frame),
        .key_weight (key_weight),
        .seek_time  (seek_time),
        .face_weight(face_weight),
        .updated    (updated),
        .table_full (table_full),
        .key_count  (key_count),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Results are sampled at the rising edge that ends their one-cycle window.
    // The watchdog counts edges at which neither a request nor a result moved.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (done)
                track_sb.check_result({face_weight, updated, table_full, key_count});
            if (done || (start && !busy)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("** morph_keyframe_interpolator_unit: FAILED **");
                $finish;
            end
        end
    end

    // Register write at the falling edge; only used while nothing is pending.
    task automatic write_cfg(mkf_reg_t idx, logic [31:0] data);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        @(negedge clk);
        cfg_we = 1'b0;
        track_sb.write_reg(idx, data);
    endtask

    // Sends one request. Inputs change at the falling edge; the request is
    // taken at the first rising edge with start high and busy low, and start
    // is dropped at the following falling edge unless another request follows.
    task automatic send_request(mkf_func_t fn, logic [23:0] frame,
                                logic signed [15:0] weight, logic [31:0] seek);
        bit taken;
        while ($urandom_range(99) < idle_pct) begin
            start = 1'b0;
            @(negedge clk);
        end
        start = 1'b1;
        func <= fn;
        key_frame <= frame;
        key_weight <= weight;
        seek_time <= seek;
        taken = 0;
        while (!taken) begin
            @(posedge clk);
            taken = !busy;
            @(negedge clk);
        end
        track_sb.note_request(fn, frame, weight, seek);
        start = 1'b0;
    endtask

    // Waits until every expected result has arrived, then lets the block
    // settle so a register write finds it idle.
    task automatic drain();
        start = 1'b0;
        while (track_sb.pending_results.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic rand_config();
        write_cfg(REG_OVERRIDE, $urandom_range(1));
        write_cfg(REG_LOOP, $urandom_range(3) == 0 ? $urandom : $urandom_range(8000));
        write_cfg(REG_SMEAR, $urandom_range(3) == 0 ? $urandom : $urandom_range(40000));
        case ($urandom_range(3))
            0: write_cfg(REG_RATE, 65536);
            1: write_cfg(REG_RATE, $urandom_range(65536));
            2: write_cfg(REG_RATE, 17'h1ffff - $urandom_range(100));
            default: write_cfg(REG_RATE, $urandom_range(3));
        endcase
        write_cfg(REG_SKIP, $urandom_range(1));
    endtask

    // A track phase: rewind, then a random mix of mostly seeks around a base frame
    // with loads of keys near that frame and the odd snapshot, rewind or noise load.
    task automatic track_phase(int count);
        int unsigned pick;
        send_request(FN_REWIND, 24'($urandom), 16'($urandom), $urandom);
        repeat (count) begin
            pick = $urandom_range(99);
            if (pick < 15)
                send_request(FN_LOAD, 24'(frame_base + $urandom_range(300)),
                             16'($urandom), $urandom);
            else if (pick < 18)
                send_request(FN_LOAD, 24'($urandom), 16'($urandom), $urandom);
            else if (pick < 80)
                send_request(FN_SEEK, 24'($urandom), 16'($urandom),
                             $urandom_range(9) == 0 ? $urandom :
                             (frame_base * 256) + $urandom_range(330 * 256));
            else if (pick < 90)
                send_request(FN_SNAPSHOT, 24'($urandom), 16'($urandom), $urandom);
            else
                send_request(FN_REWIND, 24'($urandom), 16'($urandom), $urandom);
        end
    endtask

    initial
    begin
        track_sb = new();
        quiet_cycles = 0;
        idle_pct = 0;
        rst_n = 1'b0;
        start = 1'b0;
        func = FN_LOAD;
        key_frame = '0;
        key_weight = '0;
        seek_time = '0;
        cfg_we = 1'b0;
        cfg_index = REG_OVERRIDE;
        cfg_data = '0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part: seeks on an empty and a single-key table, the skip
        // flag, extreme frames and weights, equal frames and smearing.
        send_request(FN_SEEK, 0, 0, 32'h100);
        send_request(FN_LOAD, 24'd10, 16'sh7fff, 0);
        drain();
        write_cfg(REG_SKIP, 1);
        send_request(FN_SEEK, 0, 0, 32'h500);
        drain();
        write_cfg(REG_SKIP, 0);
        send_request(FN_SEEK, 0, 0, 32'h500);
        send_request(FN_LOAD, 24'd0, 16'sh8000, 0);
        send_request(FN_LOAD, 24'd10, 16'sh1000, 0);
        send_request(FN_LOAD, 24'hffffff, -16'sd1, 0);
        send_request(FN_SEEK, 0, 0, 32'h0);
        send_request(FN_SEEK, 0, 0, 32'h580);
        send_request(FN_SEEK, 0, 0, 32'hffffffff);
        send_request(FN_SEEK, 0, 0, 32'h80);
        send_request(FN_SNAPSHOT, 0, 0, 0);
        send_request(FN_REWIND, 0, 0, 0);
        drain();
        write_cfg(REG_OVERRIDE, 1);
        write_cfg(REG_LOOP, 32'h200);
        write_cfg(REG_SMEAR, 32'h1000);
        write_cfg(REG_RATE, 32'd32768);
        send_request(FN_SEEK, 0, 0, 32'h300);
        send_request(FN_SEEK, 0, 0, 32'h2000);
        drain();
        write_cfg(REG_LOOP, 32'hffffffff);
        write_cfg(REG_SMEAR, 32'hffffffff);
        write_cfg(REG_RATE, 32'h1ffff);
        send_request(FN_SEEK, 0, 0, 32'h700);
        drain();
        write_cfg(REG_RATE, 0);
        send_request(FN_SEEK, 0, 0, 32'h900);
        drain();

        // Fill the table past its capacity so dropped loads are seen.
        write_cfg(REG_OVERRIDE, 0);
        write_cfg(REG_RATE, 65536);
        repeat (62) send_request(FN_LOAD, 24'($urandom_range(2000)), 16'($urandom),
                                 $urandom);
        repeat (20) send_request(FN_SEEK, 0, 0, $urandom_range(2100 * 256));

        // Random phases under different idling and settings. A fresh track
        // cannot be started without reset, so the full table keeps being
        // searched; the early phases use a new block state only in the sense
        // of new configuration.
        for (int ph = 0; ph < 10; ph++) begin
            drain();
            rand_config();
            case (ph % 4)
                0: idle_pct = 0;
                1: idle_pct = 74;
                2: idle_pct = 9;
                default: idle_pct = $urandom_range(50);
            endcase
            frame_base = ph % 3 == 0 ? 24'd0 : 24'($urandom_range(1900));
            track_phase(100);
        end

        drain();
        repeat (150) @(negedge clk);
        if (track_sb.error_count == 0 && track_sb.pending_results.size() == 0)
            $display("** morph_keyframe_interpolator_unit: PASSED **");
        else
            $display("** morph_keyframe_interpolator_unit: FAILED **");
        $finish;
    end
endmodule
